>>> src/cdb_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque buffer package
// Sizes, types, operation and status codes, and pointer helpers shared by the
// deque core and its channel interfaces.
// ----------------------------------------------------------------------------
package cdb_pkg;

   // Number of slots in the circular buffer.
   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic [OCC_W-1:0]           occ_type;
   typedef logic [OP_W-1:0]            op_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic signed [DATA_W-1:0]   data_type;

   // Operation codes.
   localparam op_type OP_PUSH_REAR = 2'd0;
   localparam op_type OP_POP_FRONT = 2'd1;
   localparam op_type OP_POP_REAR  = 2'd2;
   localparam op_type OP_CLEAR     = 2'd3;

   // Status codes.
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OVERFLOW  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   localparam idx_type IDX_LAST = IDX_W'(DEPTH - 1);
   localparam occ_type OCC_FULL = OCC_W'(DEPTH);

   // Advance a slot index by one, wrapping at the end of the buffer.
   function automatic idx_type idx_next(input idx_type i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   // Step a slot index back by one, wrapping at the start of the buffer.
   function automatic idx_type idx_prev(input idx_type i);
      return (i == '0) ? IDX_LAST : i - 1'b1;
   endfunction

   // The reported count carries the low bits of the occupancy.
   function automatic count_type count_field(input occ_type occ);
      logic [31:0] wide;
      wide = 32'(occ);
      return wide[COUNT_W-1:0];
   endfunction

endpackage

>>> src/cdb_req_if.sv
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel that carries one deque operation and its push value.
// ----------------------------------------------------------------------------
interface cdb_req_if;
   logic                 valid;
   logic                 ready;
   cdb_pkg::op_type      op;
   cdb_pkg::data_type    push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

>>> src/cdb_rsp_if.sv
// ----------------------------------------------------------------------------
// Deque response channel
// Valid/ready channel that carries the outcome of one deque operation.
// ----------------------------------------------------------------------------
interface cdb_rsp_if;
   logic                  valid;
   logic                  ready;
   cdb_pkg::data_type     pop_value;
   cdb_pkg::status_type   status;
   cdb_pkg::count_type    entry_count;
   logic                  is_full;
   logic                  is_empty;

   modport source (output valid, output pop_value, output status,
                   output entry_count, output is_full, output is_empty,
                   input ready);
   modport sink   (input valid, input pop_value, input status,
                   input entry_count, input is_full, input is_empty,
                   output ready);
endinterface

>>> src/cdb_slot_ram.sv
// ----------------------------------------------------------------------------
// Deque slot memory
// Simple dual-port RAM: one write port and one read port with registered
// read data. A read sees every write from earlier clock edges.
// ----------------------------------------------------------------------------
module cdb_slot_ram #(
   parameter int DATA_W  = 32,
   parameter int DEPTH_N = 16,
   parameter int ADDR_W  = (DEPTH_N > 1) ? $clog2(DEPTH_N) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] slot_mem_ff [DEPTH_N];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered output; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/circular_deque_buffer_core.sv
// ----------------------------------------------------------------------------
// Circular deque buffer core
// Pipeline: a request transfer fills the pending stage, which waits for the
//    registered read of the slot memory, then moves to the output register.
// Throughput: one operation per cycle while the response side keeps up.
// Reset: synchronous; pointers and occupancy return to zero, slot memory
//    contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_deque_buffer_core (
   input  logic clock,
   input  logic reset,
   cdb_req_if.sink   req_port,
   cdb_rsp_if.source rsp_port
);

   localparam int SUM_W = cdb_pkg::IDX_W + 2;

   // Pointer state.
   cdb_pkg::idx_type head_ff, head_in;
   cdb_pkg::idx_type tail_ff, tail_in;
   cdb_pkg::occ_type occ_ff, occ_in;

   // Pending stage: operation outcome waiting for the memory read data.
   logic                   pend_valid_ff, pend_valid_in;
   logic                   pend_pop_ff;
   cdb_pkg::status_type    pend_status_ff;
   cdb_pkg::count_type     pend_count_ff;
   logic                   pend_full_ff;
   logic                   pend_empty_ff;

   // Output register.
   logic                   out_valid_ff, out_valid_in;
   cdb_pkg::data_type      out_value_ff;
   cdb_pkg::status_type    out_status_ff;
   cdb_pkg::count_type     out_count_ff;
   logic                   out_full_ff;
   logic                   out_empty_ff;

   // Decode results.
   logic                   req_xfer;
   logic                   pend_move;
   cdb_pkg::status_type    status_c;
   logic                   pop_ok_c;
   logic                   wr_en_c;
   logic                   rd_en_c;
   cdb_pkg::idx_type       rd_addr_c;
   logic [cdb_pkg::DATA_W-1:0] rd_data;

   // Handshake: the pending stage frees up when its entry moves onward.
   assign pend_move      = pend_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !pend_valid_ff || pend_move;
   assign req_xfer       = req_port.valid && req_port.ready;

   // Operation decode and pointer update.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      status_c  = cdb_pkg::ST_OK;
      pop_ok_c  = 1'b0;
      wr_en_c   = 1'b0;
      rd_en_c   = 1'b0;
      rd_addr_c = head_ff;
      case (req_port.op)
         cdb_pkg::OP_PUSH_REAR: begin
            if (occ_ff == cdb_pkg::OCC_FULL) begin
               status_c = cdb_pkg::ST_OVERFLOW;
            end else begin
               wr_en_c = 1'b1;
               tail_in = cdb_pkg::idx_next(tail_ff);
               occ_in  = occ_ff + 1'b1;
            end
         end
         cdb_pkg::OP_POP_FRONT: begin
            if (occ_ff == '0) begin
               status_c = cdb_pkg::ST_UNDERFLOW;
            end else begin
               pop_ok_c  = 1'b1;
               rd_en_c   = 1'b1;
               rd_addr_c = head_ff;
               head_in   = cdb_pkg::idx_next(head_ff);
               occ_in    = occ_ff - 1'b1;
            end
         end
         cdb_pkg::OP_POP_REAR: begin
            if (occ_ff == '0) begin
               status_c = cdb_pkg::ST_UNDERFLOW;
            end else begin
               pop_ok_c  = 1'b1;
               rd_en_c   = 1'b1;
               rd_addr_c = cdb_pkg::idx_prev(tail_ff);
               tail_in   = cdb_pkg::idx_prev(tail_ff);
               occ_in    = occ_ff - 1'b1;
            end
         end
         default: begin
            head_in = '0;
            tail_in = '0;
            occ_in  = '0;
         end
      endcase
      // Both pointers settle at slot zero once the deque runs empty.
      if (occ_in == '0) begin
         head_in = '0;
         tail_in = '0;
      end
   end

   // Slot memory: a push writes at the tail, a pop reads its slot.
   cdb_slot_ram #(
      .DATA_W  (cdb_pkg::DATA_W),
      .DEPTH_N (cdb_pkg::DEPTH),
      .ADDR_W  (cdb_pkg::IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (req_xfer && wr_en_c),
      .wr_addr (tail_ff),
      .wr_data (req_port.push_value),
      .rd_en   (req_xfer && rd_en_c),
      .rd_addr (rd_addr_c),
      .rd_data (rd_data)
   );

   // Pointer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (req_xfer) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // Pending stage.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_xfer) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pend_pop_ff    <= pop_ok_c;
         pend_status_ff <= status_c;
         pend_count_ff  <= cdb_pkg::count_field(occ_in);
         pend_full_ff   <= (occ_in == cdb_pkg::OCC_FULL);
         pend_empty_ff  <= (occ_in == '0);
      end
   end

   // Output register; a popped value is shown only for a successful pop.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pend_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         out_value_ff  <= pend_pop_ff ? cdb_pkg::data_type'(rd_data) : '0;
         out_status_ff <= pend_status_ff;
         out_count_ff  <= pend_count_ff;
         out_full_ff   <= pend_full_ff;
         out_empty_ff  <= pend_empty_ff;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.pop_value   = out_value_ff;
   assign rsp_port.status      = out_status_ff;
   assign rsp_port.entry_count = out_count_ff;
   assign rsp_port.is_full     = out_full_ff;
   assign rsp_port.is_empty    = out_empty_ff;

   // Tail expected from head and occupancy, used by the checks below.
   logic [SUM_W-1:0] ptr_sum;
   logic [SUM_W-1:0] ptr_wrap;
   assign ptr_sum  = SUM_W'(head_ff) + SUM_W'(occ_ff);
   assign ptr_wrap = (ptr_sum >= SUM_W'(cdb_pkg::DEPTH)) ?
                     ptr_sum - SUM_W'(cdb_pkg::DEPTH) : ptr_sum;

   // The occupancy never exceeds the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cdb_pkg::OCC_FULL)
      else $error("occupancy exceeds buffer size");

   // An empty deque keeps both pointers at slot zero.
   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("pointers not settled on empty deque");

   // The tail always sits occupancy slots past the head.
   assert property (@(posedge clock) disable iff (reset)
      ptr_wrap[cdb_pkg::IDX_W-1:0] == tail_ff)
      else $error("head, tail and occupancy disagree");

   // A push that fits raises the occupancy by one.
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_port.op == cdb_pkg::OP_PUSH_REAR &&
       occ_ff != cdb_pkg::OCC_FULL) |=> (occ_ff == $past(occ_ff) + 1'b1))
      else $error("push did not grow occupancy");

   // A pending entry that cannot move keeps the request side stalled.
   assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && out_valid_ff && !rsp_port.ready) |-> !req_port.ready)
      else $error("request taken while pending stage is blocked");

endmodule
